>>> sv/black_pixel_projection_profile_core_macros.svh
// Assertion macros used by the port-level checker of the projection profile core.
`ifndef BLACK_PIXEL_PROJECTION_PROFILE_CORE_MACROS_SVH
`define BLACK_PIXEL_PROJECTION_PROFILE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bppp_pkg.sv
// Types, constants and helpers shared by the projection profile core.
package bppp_pkg;

    localparam int COORD_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int VALUE_W     = 8;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int STORE_DEPTH = 1 << COORD_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W  = $clog2(FIFO_DEPTH + 1);

    // Saturation point of every count.
    localparam int MAX_DIM     = 4096;
    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_DIM > COUNT_MAX) ? COUNT_MAX : MAX_DIM);

    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [VALUE_W-1:0]    pix_t;
    typedef logic [1:0]            opcode_t;
    typedef logic [1:0]            reg_idx_t;
    typedef logic                  kind_t;
    typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;
    typedef logic [FIFO_LVL_W-1:0] fifo_lvl_t;

    localparam opcode_t OP_PIXEL = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    localparam kind_t KIND_ROW = 1'b0;
    localparam kind_t KIND_COL = 1'b1;

    localparam reg_idx_t REG_ROI_LEFT   = 2'd0;
    localparam reg_idx_t REG_ROI_TOP    = 2'd1;
    localparam reg_idx_t REG_ROI_RIGHT  = 2'd2;
    localparam reg_idx_t REG_ROI_BOTTOM = 2'd3;

    typedef struct packed {
        kind_t  kind;
        coord_t index;
        count_t count;
    } result_t;

    typedef struct packed {
        logic   en;
        coord_t addr;
        count_t data;
    } store_wr_t;

    function automatic count_t sat_inc(input count_t v);
        return (v >= COUNT_CAP) ? COUNT_CAP : v + COUNT_W'(1);
    endfunction

endpackage

>>> sv/bppp_req_if.sv
// Input channel: one pixel, read or clear item per beat.
interface bppp_req_if;
    logic             valid;
    logic             ready;
    bppp_pkg::opcode_t opcode;
    bppp_pkg::coord_t pixel_row;
    bppp_pkg::coord_t pixel_col;
    bppp_pkg::pix_t   pixel_value;
    bppp_pkg::coord_t read_index;

    modport source (output valid, opcode, pixel_row, pixel_col, pixel_value, read_index,
                    input ready);
    modport sink   (input valid, opcode, pixel_row, pixel_col, pixel_value, read_index,
                    output ready);
endinterface

>>> sv/bppp_rsp_if.sv
// Result channel: one row count or column count per beat.
interface bppp_rsp_if;
    logic             valid;
    logic             ready;
    bppp_pkg::kind_t  result_kind;
    bppp_pkg::coord_t result_index;
    bppp_pkg::count_t black_count;

    modport source (output valid, result_kind, result_index, black_count, input ready);
    modport sink   (input valid, result_kind, result_index, black_count, output ready);
endinterface

>>> sv/bppp_col_store.sv
// Column count memory with a registered read and write-to-read forwarding.
module bppp_col_store (
    input  logic                clk,
    input  logic                rst_n,
    input  bppp_pkg::coord_t    rd_addr,
    input  bppp_pkg::store_wr_t wr,
    output bppp_pkg::count_t    rd_data
);
    import bppp_pkg::*;

    count_t mem [STORE_DEPTH];
    count_t rd_data_reg;
    count_t fwd_data_reg;
    logic   fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    // A write landing on the entry being read in the same cycle is not seen by
    // the memory read, so its data is handed over directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

>>> sv/bppp_out_fifo.sv
// Small result queue that decouples the update pipeline from the result channel.
module bppp_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bppp_pkg::result_t   push_data,
    input  logic                pop,
    output logic                not_empty,
    output bppp_pkg::result_t   head,
    output bppp_pkg::fifo_lvl_t level
);
    import bppp_pkg::*;

    result_t   entries_reg [FIFO_DEPTH];
    fifo_ptr_t wr_ptr_reg;
    fifo_ptr_t rd_ptr_reg;
    fifo_lvl_t level_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + FIFO_LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - FIFO_LVL_W'(1);
            end
        end
    end

    assign not_empty = (level_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

>>> sv/black_pixel_projection_profile_core.sv
// Black-pixel projection profile core. Pixels of a binarized page arrive with
// their absolute row and column; those inside the configured inclusive region
// whose value is zero are counted per column, in a 4096-entry memory indexed by
// column minus roi_left, and per row, in a single accumulator. When the pixel
// at column roi_right of an in-region row arrives, the row count (including
// that pixel) leaves as a result of kind 0 with the row index relative to
// roi_top. A read item returns the stored count at read_index as a result of
// kind 1; a clear item zeroes every column count and gives no result. Counts
// stop at MAX_DIM. The block takes one item per clock while it is not sweeping
// and the result queue has room: a column update is a read-modify-write on the
// count memory, read at the accepting edge and written back from the update
// stage, with forwarding when consecutive pixels hit the same column. A result
// is registered in the update stage and then in the result queue before it is
// presented on the result channel. Results wait in a four-beat queue, so input
// keeps flowing while the result side stalls, until the queue together with the
// item in the update stage holds four beats. After reset and after every clear
// item the core sweeps the memory to zero, one entry per cycle; no item is
// accepted until the sweep ends, while register writes are still taken.
// The region registers sit on an APB-style port, one per 32-bit word.
module black_pixel_projection_profile_core (
    input  logic                                clk,
    input  logic                                rst_n,
    bppp_req_if.sink                            req,
    bppp_rsp_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bppp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bppp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bppp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import bppp_pkg::*;

    // Region registers.
    coord_t roi_left_reg;
    coord_t roi_top_reg;
    coord_t roi_right_reg;
    coord_t roi_bottom_reg;

    reg_idx_t reg_sel;
    coord_t   reg_rdata;
    logic     cfg_write;

    // Clearing sweep.
    logic   sweep_active_reg;
    logic   sweep_active_next;
    coord_t sweep_addr_reg;

    // Accept stage.
    logic   accept;
    logic   in_region;
    logic   is_pixel;
    logic   is_read;
    coord_t acc_addr;

    // Update stage.
    logic   s1_valid_reg;
    logic   s1_pixel_reg;
    logic   s1_read_reg;
    logic   s1_black_reg;
    logic   s1_first_reg;
    logic   s1_last_reg;
    coord_t s1_addr_reg;
    coord_t s1_index_reg;

    count_t row_acc_reg;
    count_t row_acc_next;
    count_t row_base;
    count_t row_sum;
    count_t col_cur;

    store_wr_t store_wr;
    result_t   push_data;
    logic      push;
    logic      q_not_empty;
    result_t   q_head;
    fifo_lvl_t q_level;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // served combinationally from the addressed register.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_left_reg   <= '0;
            roi_top_reg    <= '0;
            roi_right_reg  <= '1;
            roi_bottom_reg <= '1;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_ROI_LEFT:   roi_left_reg   <= pwdata[COORD_W-1:0];
                REG_ROI_TOP:    roi_top_reg    <= pwdata[COORD_W-1:0];
                REG_ROI_RIGHT:  roi_right_reg  <= pwdata[COORD_W-1:0];
                REG_ROI_BOTTOM: roi_bottom_reg <= pwdata[COORD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ROI_LEFT:   reg_rdata = roi_left_reg;
            REG_ROI_TOP:    reg_rdata = roi_top_reg;
            REG_ROI_RIGHT:  reg_rdata = roi_right_reg;
            REG_ROI_BOTTOM: reg_rdata = roi_bottom_reg;
        endcase
    end

    assign prdata = APB_DATA_W'(reg_rdata);

    // ------------------------------------------------------------------
    // Accept stage. Input is held off during a sweep and whenever the
    // result queue could not absorb the items already in flight.
    // ------------------------------------------------------------------
    assign req.ready = !sweep_active_reg
                       && ((q_level + FIFO_LVL_W'(s1_valid_reg)) <= FIFO_LVL_W'(FIFO_DEPTH - 1));
    assign accept    = req.valid && req.ready;

    assign in_region = (req.pixel_row >= roi_top_reg) && (req.pixel_row <= roi_bottom_reg)
                       && (req.pixel_col >= roi_left_reg) && (req.pixel_col <= roi_right_reg);
    assign is_pixel  = (req.opcode == OP_PIXEL) && in_region;
    assign is_read   = (req.opcode == OP_READ);

    // The count memory is read at the accepting edge, for a pixel at its
    // column offset, for a read at the requested index.
    assign acc_addr  = is_read ? req.read_index : (req.pixel_col - roi_left_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pixel_reg <= 1'b0;
            s1_read_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_pixel_reg <= accept && is_pixel;
            s1_read_reg  <= accept && is_read;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_black_reg <= (req.pixel_value == '0);
        s1_first_reg <= (req.pixel_col == roi_left_reg);
        s1_last_reg  <= (req.pixel_col == roi_right_reg);
        s1_addr_reg  <= acc_addr;
        s1_index_reg <= is_read ? req.read_index : (req.pixel_row - roi_top_reg);
    end

    // ------------------------------------------------------------------
    // Column count memory and clearing sweep. The sweep owns the write port
    // while it runs; no pixel is in the update stage then.
    // ------------------------------------------------------------------
    always_comb
    begin
        sweep_active_next = sweep_active_reg;
        if (accept && (req.opcode == OP_CLEAR))
        begin
            sweep_active_next = 1'b1;
        end
        else if (sweep_active_reg && (sweep_addr_reg == COORD_W'(STORE_DEPTH - 1)))
        begin
            sweep_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_active_reg <= 1'b1;
            sweep_addr_reg   <= '0;
        end
        else
        begin
            sweep_active_reg <= sweep_active_next;
            if (sweep_active_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + COORD_W'(1);
            end
        end
    end

    always_comb
    begin
        if (sweep_active_reg)
        begin
            store_wr.en   = 1'b1;
            store_wr.addr = sweep_addr_reg;
            store_wr.data = '0;
        end
        else
        begin
            store_wr.en   = s1_valid_reg && s1_pixel_reg && s1_black_reg;
            store_wr.addr = s1_addr_reg;
            store_wr.data = sat_inc(col_cur);
        end
    end

    bppp_col_store u_col_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (acc_addr),
        .wr      (store_wr),
        .rd_data (col_cur)
    );

    // ------------------------------------------------------------------
    // Row accumulator. A pixel at the left edge restarts the row; the pixel
    // at the right edge emits the row total and clears it.
    // ------------------------------------------------------------------
    assign row_base = s1_first_reg ? '0 : row_acc_reg;
    assign row_sum  = s1_black_reg ? sat_inc(row_base) : row_base;

    always_comb
    begin
        row_acc_next = row_acc_reg;
        if (s1_valid_reg && s1_pixel_reg)
        begin
            row_acc_next = s1_last_reg ? '0 : row_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_acc_reg <= '0;
        end
        else
        begin
            row_acc_reg <= row_acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Results.
    // ------------------------------------------------------------------
    assign push = s1_valid_reg && ((s1_pixel_reg && s1_last_reg) || s1_read_reg);

    always_comb
    begin
        push_data.index = s1_index_reg;
        if (s1_read_reg)
        begin
            push_data.kind  = KIND_COL;
            push_data.count = col_cur;
        end
        else
        begin
            push_data.kind  = KIND_ROW;
            push_data.count = row_sum;
        end
    end

    bppp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (rsp.valid && rsp.ready),
        .not_empty (q_not_empty),
        .head      (q_head),
        .level     (q_level)
    );

    assign rsp.valid        = q_not_empty;
    assign rsp.result_kind  = q_head.kind;
    assign rsp.result_index = q_head.index;
    assign rsp.black_count  = q_head.count;

endmodule

>>> sv/bppp_checker.sv
// Port-level checker for the projection profile core and its bind statement.
`include "black_pixel_projection_profile_core_macros.svh"

module bppp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input bppp_pkg::opcode_t req_opcode,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input bppp_pkg::kind_t   rsp_result_kind,
    input bppp_pkg::coord_t  rsp_result_index,
    input bppp_pkg::count_t  rsp_black_count
);
    import bppp_pkg::*;

    // A clear starts the memory sweep, which holds off input right away.
    `BPPP_ASSERT_NEXT(a_clear_holds_off, req_valid && req_ready && req_opcode == OP_CLEAR, !req_ready, "input accepted right after a clear")

    // No count ever passes the saturation point.
    `BPPP_ASSERT_NOW(a_count_capped, rsp_valid, rsp_black_count <= COUNT_CAP, "count above saturation point")

    // A stalled result beat stays put.
    `BPPP_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_result_index) && $stable(rsp_black_count), "stalled result beat changed")

endmodule

bind black_pixel_projection_profile_core bppp_checker u_bppp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_opcode       (req.opcode),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_kind  (rsp.result_kind),
    .rsp_result_index (rsp.result_index),
    .rsp_black_count  (rsp.black_count)
);
